### design/frdf_pkg.sv
// Shared types and constants for the flood relay duplicate filter.
`default_nettype none

package frdf_pkg;

    localparam int ID_W      = 32;
    localparam int MAC_W     = 48;
    localparam int HOP_W     = 8;
    localparam int EV_KEY_W  = ID_W + MAC_W;
    localparam int ACK_KEY_W = ID_W + MAC_W + MAC_W;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 24;
    localparam int VERDICT_W = 2;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_ACK   = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_DUP    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd2;

    localparam logic [HOP_W-1:0] REPLY_TTL_RESET = 8'd5;

    typedef struct packed {
        logic load_in;
        logic scan;
        logic set_seen;
        logic insert;
        logic load_out;
    } frdf_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic out_free;
    } frdf_status_t;

endpackage

`default_nettype wire

### design/frdf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module frdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/frdf_ctrl.sv
// Controller state machine that sequences request capture, cache scan, insert and result.
`default_nettype none

module frdf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire frdf_pkg::frdf_status_t status,
    output frdf_pkg::frdf_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } frdf_state_t;

    frdf_state_t state_reg;
    frdf_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit)
                begin
                    cmd.set_seen = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (status.scan_done)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/frdf_dp.sv
// Datapath with the two seen caches, their fill and oldest pointers, and the result register.
`default_nettype none

module frdf_dp #(
    parameter int CACHE_DEPTH = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [frdf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [frdf_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic [frdf_pkg::VERDICT_W-1:0]           m_tuser,
    input  wire logic                                cfg_wr_en,
    input  wire logic [frdf_pkg::HOP_W-1:0]          cfg_wr_data,
    input  wire frdf_pkg::frdf_cmd_t                 cmd,
    output frdf_pkg::frdf_status_t                   status
);

    localparam int IW = $clog2(CACHE_DEPTH);
    localparam int FW = $clog2(CACHE_DEPTH + 1);
    localparam int SW = FW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(CACHE_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(CACHE_DEPTH);

    logic                          op_reg;
    logic [frdf_pkg::ID_W-1:0]     id_reg;
    logic [frdf_pkg::MAC_W-1:0]    sender_reg;
    logic [frdf_pkg::MAC_W-1:0]    acked_reg;
    logic [frdf_pkg::HOP_W-1:0]    hops_reg;
    logic                          auth_reg;

    logic [FW-1:0]                 ev_fill_reg;
    logic [FW-1:0]                 ack_fill_reg;
    logic [IW-1:0]                 ev_oldest_reg;
    logic [IW-1:0]                 ack_oldest_reg;
    logic [FW-1:0]                 k_reg;
    logic                          pend_reg;
    logic                          seen_reg;
    logic [frdf_pkg::HOP_W-1:0]    reply_ttl_reg;

    logic                          m_tvalid_reg;
    logic [frdf_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [frdf_pkg::VERDICT_W-1:0] m_tuser_reg;

    logic [FW-1:0]                 fill_sel;
    logic [IW-1:0]                 oldest_sel;
    logic [SW-1:0]                 rd_sum;
    logic [SW-1:0]                 rd_wrap;
    logic [SW-1:0]                 ins_sum;
    logic [SW-1:0]                 ins_wrap;
    logic [IW-1:0]                 rd_addr;
    logic [IW-1:0]                 slot;
    logic [IW-1:0]                 oldest_inc;
    logic                          full;
    logic                          rd_go;
    logic                          match;
    logic                          ev_we;
    logic                          ack_we;

    logic [frdf_pkg::EV_KEY_W-1:0]  ev_key;
    logic [frdf_pkg::ACK_KEY_W-1:0] ack_key;
    logic [frdf_pkg::EV_KEY_W-1:0]  ev_rd_data;
    logic [frdf_pkg::ACK_KEY_W-1:0] ack_rd_data;

    logic [frdf_pkg::VERDICT_W-1:0] verdict;
    logic                           deliver;
    logic                           send_reply;
    logic [frdf_pkg::HOP_W-1:0]     reply_hops;
    logic                           relay;
    logic [frdf_pkg::HOP_W-1:0]     relay_hops;

    assign fill_sel   = (op_reg == frdf_pkg::OP_ACK) ? ack_fill_reg : ev_fill_reg;
    assign oldest_sel = (op_reg == frdf_pkg::OP_ACK) ? ack_oldest_reg : ev_oldest_reg;

    assign rd_sum   = SW'(oldest_sel) + SW'(k_reg);
    assign rd_wrap  = (rd_sum >= DEPTH_S) ? (rd_sum - DEPTH_S) : rd_sum;
    assign rd_addr  = rd_wrap[IW-1:0];
    assign ins_sum  = SW'(oldest_sel) + SW'(fill_sel);
    assign ins_wrap = (ins_sum >= DEPTH_S) ? (ins_sum - DEPTH_S) : ins_sum;
    assign full     = (fill_sel == DEPTH_F);
    assign slot     = full ? oldest_sel : ins_wrap[IW-1:0];
    assign oldest_inc = ((SW'(oldest_sel) + SW'(1)) == DEPTH_S) ? '0 : (oldest_sel + IW'(1));

    assign rd_go  = cmd.scan && (k_reg < fill_sel);
    assign ev_we  = cmd.insert && (op_reg == frdf_pkg::OP_EVENT);
    assign ack_we = cmd.insert && (op_reg == frdf_pkg::OP_ACK);

    assign ev_key  = {sender_reg, id_reg};
    assign ack_key = {sender_reg, acked_reg, id_reg};
    assign match   = (op_reg == frdf_pkg::OP_ACK) ? (ack_rd_data == ack_key)
                                                  : (ev_rd_data == ev_key);

    assign status.hit       = cmd.scan && pend_reg && match;
    assign status.scan_done = !rd_go && !pend_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    frdf_ram #(
        .WIDTH (frdf_pkg::EV_KEY_W),
        .DEPTH (CACHE_DEPTH)
    ) u_ev_ram (
        .clk     (clk),
        .wr_en   (ev_we),
        .wr_addr (slot),
        .wr_data (ev_key),
        .rd_en   (rd_go),
        .rd_addr (rd_addr),
        .rd_data (ev_rd_data)
    );

    frdf_ram #(
        .WIDTH (frdf_pkg::ACK_KEY_W),
        .DEPTH (CACHE_DEPTH)
    ) u_ack_ram (
        .clk     (clk),
        .wr_en   (ack_we),
        .wr_addr (slot),
        .wr_data (ack_key),
        .rd_en   (rd_go),
        .rd_addr (rd_addr),
        .rd_data (ack_rd_data)
    );

    always_comb
    begin
        verdict    = frdf_pkg::VERDICT_DUP;
        deliver    = 1'b0;
        send_reply = 1'b0;
        reply_hops = '0;
        relay      = 1'b0;
        relay_hops = '0;
        priority if (seen_reg)
        begin
            verdict = frdf_pkg::VERDICT_DUP;
        end
        else if (!auth_reg)
        begin
            verdict = frdf_pkg::VERDICT_DROP;
        end
        else
        begin
            verdict = frdf_pkg::VERDICT_ACCEPT;
            if (op_reg == frdf_pkg::OP_EVENT)
            begin
                deliver    = 1'b1;
                send_reply = 1'b1;
                reply_hops = reply_ttl_reg;
            end
            if (hops_reg != '0)
            begin
                relay      = 1'b1;
                relay_hops = hops_reg - frdf_pkg::HOP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_fill_reg    <= '0;
            ack_fill_reg   <= '0;
            ev_oldest_reg  <= '0;
            ack_oldest_reg <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            seen_reg       <= 1'b0;
            reply_ttl_reg  <= frdf_pkg::REPLY_TTL_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                reply_ttl_reg <= cfg_wr_data;
            end
            if (cmd.load_in)
            begin
                k_reg    <= '0;
                pend_reg <= 1'b0;
                seen_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= rd_go;
                if (rd_go)
                begin
                    k_reg <= k_reg + FW'(1);
                end
            end
            if (cmd.set_seen)
            begin
                seen_reg <= 1'b1;
            end
            if (ev_we)
            begin
                if (full)
                begin
                    ev_oldest_reg <= oldest_inc;
                end
                else
                begin
                    ev_fill_reg <= ev_fill_reg + FW'(1);
                end
            end
            if (ack_we)
            begin
                if (full)
                begin
                    ack_oldest_reg <= oldest_inc;
                end
                else
                begin
                    ack_fill_reg <= ack_fill_reg + FW'(1);
                end
            end
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= s_tuser;
            id_reg     <= s_tdata[31:0];
            sender_reg <= s_tdata[79:32];
            acked_reg  <= s_tdata[127:80];
            hops_reg   <= s_tdata[135:128];
            auth_reg   <= s_tdata[136];
        end
        if (cmd.load_out)
        begin
            m_tuser_reg <= verdict;
            m_tdata_reg <= {5'd0, relay_hops, relay, reply_hops, send_reply, deliver};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### design/flood_relay_duplicate_filter_top.sv
// Top level of the flood relay duplicate filter: controller plus datapath.
//
// Each request on the slave stream is one received mesh packet, an event or an
// acknowledgement. Its key is looked up in the matching seen cache, a first-in
// first-out store of CACHE_DEPTH keys, and one result leaves on the master stream
// with the verdict in m_tuser and the delivery and relay decisions in m_tdata.
// The scan reads one cache entry per cycle from a registered RAM until the
// selected cache has been read through, and a hit ends the scan early. One
// request is worked on at a time, and s_tready is high only while the block
// waits for a request, so a new request is not accepted before the last one's
// result has been loaded into the result register.
// The result register frees the block from the receiver: when m_tready is low
// the block still accepts and scans the next request, and holds in its final
// cycle only until the stored result is taken.
// Reset empties both caches through their fill counts and sets reply_ttl to 5.
// The reply_ttl register is written with cfg_wr_en and cfg_wr_data.
`default_nettype none

module flood_relay_duplicate_filter_top #(
    parameter int CACHE_DEPTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // message_id[31:0], sender_origin[79:32], acked_event_origin[127:80],
    // hop_limit[135:128], sender_authorized[136], zero pad above.
    input  wire logic [143:0] s_tdata,
    // operation[0].
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // deliver[0], send_reply[1], reply_hops[9:2], relay[10], relay_hops[18:11],
    // zero pad above.
    output logic [23:0]       m_tdata,
    // verdict[1:0].
    output logic [1:0]        m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data
);

    frdf_pkg::frdf_cmd_t    cmd;
    frdf_pkg::frdf_status_t status;

    frdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frdf_dp #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

### tb/flood_relay_duplicate_filter_top_test.sv
// Self-checking testbench for the flood relay duplicate filter top level.
`timescale 1ns / 100ps

module flood_relay_duplicate_filter_top_test;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 200;
    localparam int HISTORY_KEEP = 100;
    localparam int AWAIT_SLOTS = 16;

    typedef struct packed {
        logic        op;
        logic [31:0] id;
        logic [47:0] sender;
        logic [47:0] acked;
        logic [7:0]  hops;
        logic        auth;
    } mesh_packet_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       deliver;
        logic       send_reply;
        logic [7:0] reply_hops;
        logic       relay;
        logic [7:0] relay_hops;
    } filter_verdict_t;

    class verdict_scoreboard;
        logic [127:0]    seen_keys [2][DEPTH];
        int              fill [2];
        int              oldest [2];
        logic [7:0]      reply_ttl;
        filter_verdict_t awaited_verdicts [AWAIT_SLOTS];
        int              await_head;
        int              await_count;
        int              mismatch_count;

        function new();
            fill = '{0, 0};
            oldest = '{0, 0};
            reply_ttl = frdf_pkg::REPLY_TTL_RESET;
            await_head = 0;
            await_count = 0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return await_count;
        endfunction

        // Looks the packet up in its seen cache, inserts it on a miss, and
        // queues the verdict the block has to produce.
        function void note_packet(mesh_packet_t p);
            filter_verdict_t r;
            logic [127:0]    key;
            logic            seen;
            int              idx;
            int              slot;
            r = '0;
            seen = 1'b0;
            if (p.op == frdf_pkg::OP_ACK)
                key = {p.id, p.acked, p.sender};
            else
                key = {p.id, p.sender, 48'd0};
            for (int k = 0; k < fill[p.op]; k++)
            begin
                idx = (oldest[p.op] + k) % DEPTH;
                if (seen_keys[p.op][idx] == key)
                    seen = 1'b1;
            end
            if (!seen)
            begin
                if (fill[p.op] < DEPTH)
                begin
                    slot = (oldest[p.op] + fill[p.op]) % DEPTH;
                    fill[p.op] = fill[p.op] + 1;
                end
                else
                begin
                    slot = oldest[p.op];
                    oldest[p.op] = (slot + 1) % DEPTH;
                end
                seen_keys[p.op][slot] = key;
            end
            if (seen)
                r.verdict = frdf_pkg::VERDICT_DUP;
            else if (!p.auth)
                r.verdict = frdf_pkg::VERDICT_DROP;
            else
            begin
                r.verdict = frdf_pkg::VERDICT_ACCEPT;
                if (p.op == frdf_pkg::OP_EVENT)
                begin
                    r.deliver = 1'b1;
                    r.send_reply = 1'b1;
                    r.reply_hops = reply_ttl;
                end
                if (p.hops != 8'd0)
                begin
                    r.relay = 1'b1;
                    r.relay_hops = p.hops - 8'd1;
                end
            end
            awaited_verdicts[(await_head + await_count) % AWAIT_SLOTS] = r;
            await_count = await_count + 1;
        endfunction

        task report_mismatch(input string msg);
            if (mismatch_count < 100)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_verdict(input logic [1:0] verdict, input logic [23:0] data);
            filter_verdict_t e;
            if (await_count == 0)
            begin
                report_mismatch($sformatf("unexpected result verdict=%0d data=%h",
                                          verdict, data));
                return;
            end
            e = awaited_verdicts[await_head];
            await_head = (await_head + 1) % AWAIT_SLOTS;
            await_count = await_count - 1;
            if (verdict !== e.verdict)
                report_mismatch($sformatf("verdict %0d, want %0d", verdict, e.verdict));
            if (data[0] !== e.deliver)
                report_mismatch($sformatf("deliver %b, want %b", data[0], e.deliver));
            if (data[1] !== e.send_reply)
                report_mismatch($sformatf("send_reply %b, want %b", data[1], e.send_reply));
            if (data[9:2] !== e.reply_hops)
                report_mismatch($sformatf("reply_hops %0d, want %0d", data[9:2],
                                          e.reply_hops));
            if (data[10] !== e.relay)
                report_mismatch($sformatf("relay %b, want %b", data[10], e.relay));
            if (data[18:11] !== e.relay_hops)
                report_mismatch($sformatf("relay_hops %0d, want %0d", data[18:11],
                                          e.relay_hops));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [143:0]   s_tdata;
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [23:0]    m_tdata;
    logic [1:0]     m_tuser;
    logic           cfg_wr_en;
    logic [7:0]     cfg_wr_data;

    verdict_scoreboard book;
    mesh_packet_t      recent_events [HISTORY_KEEP];
    mesh_packet_t      recent_acks [HISTORY_KEEP];
    int                event_count = 0;
    int                event_wr = 0;
    int                ack_count = 0;
    int                ack_wr = 0;
    logic              idle_on;
    int                stall_left;
    int                cycle_count;

    flood_relay_duplicate_filter_top #(
        .CACHE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_verdict(m_tuser, m_tdata);
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic mesh_packet_t make_packet(input logic op, input logic [31:0] id,
                                                 input logic [47:0] sender,
                                                 input logic [47:0] acked,
                                                 input logic [7:0] hops, input logic auth);
        mesh_packet_t p;
        p.op = op;
        p.id = id;
        p.sender = sender;
        p.acked = acked;
        p.hops = hops;
        p.auth = auth;
        return p;
    endfunction

    // Most packets reuse a recent key, some with one bit changed, so that hits,
    // near misses and evictions at the cache boundary all occur.
    function automatic mesh_packet_t random_packet();
        mesh_packet_t p;
        mesh_packet_t old;
        int           mode;
        int           bit_pos;
        p.op = ($urandom_range(0, 1) == 0) ? frdf_pkg::OP_EVENT : frdf_pkg::OP_ACK;
        p.id = $urandom;
        p.sender = rand_mac();
        p.acked = rand_mac();
        mode = $urandom_range(0, 99);
        if (mode < 55 && p.op == frdf_pkg::OP_EVENT && event_count > 0)
            old = recent_events[$urandom_range(0, event_count - 1)];
        else if (mode < 55 && p.op == frdf_pkg::OP_ACK && ack_count > 0)
            old = recent_acks[$urandom_range(0, ack_count - 1)];
        else
            mode = (mode < 55) ? 99 : mode;
        if (mode < 55)
        begin
            p.id = old.id;
            p.sender = old.sender;
            p.acked = old.acked;
            if (mode >= 45)
            begin
                bit_pos = $urandom_range(0, 47);
                case ($urandom_range(0, 2))
                    0: p.id[bit_pos % 32] = ~p.id[bit_pos % 32];
                    1: p.sender[bit_pos] = ~p.sender[bit_pos];
                    default: p.acked[bit_pos] = ~p.acked[bit_pos];
                endcase
            end
        end
        else if (mode >= 88)
        begin
            p.id = $urandom_range(0, 3);
            p.sender = 48'($urandom_range(0, 3));
            p.acked = 48'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 9))
            0: p.hops = 8'd0;
            1: p.hops = 8'd1;
            2: p.hops = 8'd255;
            default: p.hops = 8'($urandom_range(0, 255));
        endcase
        p.auth = ($urandom_range(0, 3) != 0);
        if (p.op == frdf_pkg::OP_EVENT)
        begin
            recent_events[event_wr] = p;
            event_wr = (event_wr + 1) % HISTORY_KEEP;
            if (event_count < HISTORY_KEEP)
                event_count = event_count + 1;
        end
        else
        begin
            recent_acks[ack_wr] = p;
            ack_wr = (ack_wr + 1) % HISTORY_KEEP;
            if (ack_count < HISTORY_KEEP)
                ack_count = ack_count + 1;
        end
        return p;
    endfunction

    task automatic send_request(input mesh_packet_t p);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= p.op;
        s_tdata <= {7'd0, p.auth, p.hops, p.acked, p.sender, p.id};
        do @(posedge clk); while (!s_tready);
        book.note_packet(p);
    endtask

    task automatic wait_until_drained();
        while (book.pending() != 0) @(negedge clk);
    endtask

    task automatic write_reply_ttl(input logic [7:0] ttl);
        wait_until_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ttl;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.reply_ttl = ttl;
    endtask

    task automatic run_directed();
        send_request(make_packet(frdf_pkg::OP_EVENT, 32'd0, 48'd0, 48'd0, 8'd0, 1'b1));
        send_request(make_packet(frdf_pkg::OP_EVENT, 32'd0, 48'd0, 48'd0, 8'd9, 1'b1));
        send_request(make_packet(frdf_pkg::OP_EVENT, '1, '1, 48'd0, 8'd255, 1'b1));
        send_request(make_packet(frdf_pkg::OP_EVENT, 32'd1, '1, '1, 8'd1, 1'b0));
        send_request(make_packet(frdf_pkg::OP_EVENT, 32'd1, '1, 48'd7, 8'd1, 1'b1));
        send_request(make_packet(frdf_pkg::OP_ACK, 32'd0, 48'd0, 48'd0, 8'd3, 1'b1));
        send_request(make_packet(frdf_pkg::OP_ACK, 32'd0, 48'd0, 48'd0, 8'd3, 1'b1));
        send_request(make_packet(frdf_pkg::OP_ACK, '1, '1, '1, 8'd0, 1'b1));
        send_request(make_packet(frdf_pkg::OP_ACK, '1, '1, 48'd1, 8'd4, 1'b0));
        send_request(make_packet(frdf_pkg::OP_ACK, '1, '1, 48'd0, 8'd255, 1'b1));
        send_request(make_packet(frdf_pkg::OP_ACK, '1, 48'd0, '1, 8'd1, 1'b1));
        send_request(make_packet(frdf_pkg::OP_EVENT, '1, 48'h8000_0000_0000, 48'd0,
                                 8'd1, 1'b1));
        send_request(make_packet(frdf_pkg::OP_EVENT, 32'h8000_0000, '1, 48'd0, 8'd128,
                                 1'b0));
        send_request(make_packet(frdf_pkg::OP_EVENT, 32'd0, 48'd0, '1, 8'd2, 1'b0));
        send_request(make_packet(frdf_pkg::OP_ACK, 32'd0, 48'd0, 48'd0, 8'd0, 1'b0));
        s_tvalid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_packet());
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] ttl_plan [8];
        ttl_plan = '{8'd255, 8'd0, 8'd5, 8'd1, 8'd5, 8'd128, 8'd5, 8'd254};
        ttl_plan[2] = 8'($urandom_range(0, 255));
        ttl_plan[4] = 8'($urandom_range(0, 255));
        ttl_plan[6] = 8'($urandom_range(0, 255));
        book = new();
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= frdf_pkg::OP_EVENT;
        m_tready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        idle_on = 1'b1;
        stall_left <= 0;
        cycle_count <= 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reply_ttl(ttl_plan[ph]);
            idle_on = (ph != 7);
            run_random(PHASE_ITEMS);
        end
        wait_until_drained();
        repeat (DEPTH + 16) @(posedge clk);
        if (book.mismatch_count == 0 && book.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
design/frdf_pkg.sv
design/frdf_ram.sv
design/frdf_ctrl.sv
design/frdf_dp.sv
design/flood_relay_duplicate_filter_top.sv
tb/flood_relay_duplicate_filter_top_test.sv
